// File: rtl/core/wgne_pkg.sv
// ----------------------------------------------------------------------------
// wgne_pkg
// Types and constants shared by the grid neighbour expansion core.
// ----------------------------------------------------------------------------
package wgne_pkg;

    localparam int ID_BITS      = 24;
    localparam int WT_BITS      = 8;
    localparam int CFG_BITS     = 16;
    localparam int COST_BITS    = 24;
    localparam int SUM_BITS     = 10;
    localparam int PROD_BITS    = SUM_BITS + CFG_BITS;
    localparam int NUM_DIR      = 8;
    localparam int DIR_BITS     = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_BITS-1:0] PAD_WIDTH_RST = 16'd1024;
    localparam logic [CFG_BITS-1:0] STRAIGHT_RST  = 16'd1000;
    localparam logic [CFG_BITS-1:0] DIAGONAL_RST  = 16'd1414;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_N  = 3'd0,
        DIR_NE = 3'd1,
        DIR_E  = 3'd2,
        DIR_SE = 3'd3,
        DIR_S  = 3'd4,
        DIR_SW = 3'd5,
        DIR_W  = 3'd6,
        DIR_NW = 3'd7
    } t_dir;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAD_WIDTH = 2'd0,
        CFG_STRAIGHT  = 2'd1,
        CFG_DIAGONAL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_BITS-1:0] center_id;
        logic [WT_BITS-1:0] weight_nw;
        logic [WT_BITS-1:0] weight_n;
        logic [WT_BITS-1:0] weight_ne;
        logic [WT_BITS-1:0] weight_w;
        logic [WT_BITS-1:0] weight_c;
        logic [WT_BITS-1:0] weight_e;
        logic [WT_BITS-1:0] weight_sw;
        logic [WT_BITS-1:0] weight_s;
        logic [WT_BITS-1:0] weight_se;
    } t_in_item;

    typedef struct packed {
        logic [ID_BITS-1:0]   neighbour_id;
        logic [DIR_BITS-1:0]  direction;
        logic [COST_BITS-1:0] step_cost;
        logic                 found;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [SUM_BITS-1:0] wsum;
        logic [CFG_BITS-1:0] factor;
        logic                diag;
        logic [ID_BITS-1:0]  id;
    } t_lane_req;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [COST_BITS-1:0] cost;
    } t_lane_res;

endpackage

// File: rtl/core/wgne_lane.sv
// ----------------------------------------------------------------------------
// wgne_lane
// One direction lane: scales the weight sum by the move cost and holds the
// neighbour id and cost until the merge stage has sent them.
// ----------------------------------------------------------------------------
module wgne_lane
    import wgne_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  t_lane_req i_req,
    output t_lane_res o_res
);

    logic [PROD_BITS-1:0] prod;
    t_lane_res            n_res;
    t_lane_res            r_res;

    always_comb begin
        prod     = PROD_BITS'(i_req.wsum) * PROD_BITS'(i_req.factor);
        n_res.id = i_req.id;
        if (i_req.diag) begin
            n_res.cost = prod[COST_BITS+1:2];
        end else begin
            n_res.cost = prod[COST_BITS:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: rtl/core/wgne_merge.sv
// ----------------------------------------------------------------------------
// wgne_merge
// Merge stage: walks the open lanes in direction order and sends one result
// per transfer through an output register.
// ----------------------------------------------------------------------------
module wgne_merge
    import wgne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_load,
    input  logic [NUM_DIR-1:0] i_open,
    input  logic [ID_BITS-1:0] i_center,
    input  t_lane_res          i_res [NUM_DIR],
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data
);

    logic               r_have;
    logic [NUM_DIR-1:0] r_pend;
    logic [ID_BITS-1:0] r_center;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               n_have;
    logic [NUM_DIR-1:0] n_pend;
    logic               n_out_valid;

    logic [DIR_BITS-1:0] sel;
    logic [NUM_DIR-1:0]  pend_rest;
    logic                out_ready;
    logic                emit;
    logic                is_last;
    logic                take;
    t_out_item           pick;

    always_comb begin
        sel = DIR_N;
        for (int i = NUM_DIR - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = DIR_BITS'(i);
            end
        end
        pend_rest = r_pend & ~(NUM_DIR'(1) << sel);
        is_last   = (pend_rest == '0);
        out_ready = !r_out_valid || !i_out_stall;
        emit      = r_have && out_ready;
        take      = !r_have || (emit && is_last);
        o_load    = i_in_valid && take;

        if (r_pend == '0) begin
            pick.neighbour_id = r_center;
            pick.direction    = DIR_N;
            pick.step_cost    = '0;
            pick.found        = 1'b0;
        end else begin
            pick.neighbour_id = i_res[sel].id;
            pick.direction    = sel;
            pick.step_cost    = i_res[sel].cost;
            pick.found        = 1'b1;
        end
        pick.last = is_last;

        n_have = r_have;
        n_pend = r_pend;
        if (o_load) begin
            n_have = 1'b1;
            n_pend = i_open;
        end else if (emit && is_last) begin
            n_have = 1'b0;
        end else if (emit) begin
            n_pend = pend_rest;
        end

        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (o_load) begin
            r_center <= i_center;
        end
        if (emit) begin
            r_out <= pick;
        end
    end

    assign o_in_stall  = !take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/weighted_grid_neighbour_expand_core.sv
// Order: a transfer registers the lane results and open mask, then the merge
// output register holds each result. Throughput: one result per cycle while
// the output is not stalled, set by the single merge result port; an item with
// k open neighbours gives k results (one when none is open), at most 8.
// Reset: synchronous, active low; clears the valid flags and reloads the cost and
// width registers with their defaults.
// ----------------------------------------------------------------------------
// weighted_grid_neighbour_expand_core
// Expands one grid cell into its open 8-neighbours with ids and move costs.
// ----------------------------------------------------------------------------
module weighted_grid_neighbour_expand_core
    import wgne_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    logic [CFG_BITS-1:0] r_pad_width;
    logic [CFG_BITS-1:0] r_straight;
    logic [CFG_BITS-1:0] r_diagonal;

    logic [ID_BITS-1:0]  up;
    logic [ID_BITS-1:0]  dn;
    logic [SUM_BITS-1:0] nw, n, ne, w, o, e, sw, s, se;
    logic [NUM_DIR-1:0]  open;
    logic                load;
    t_lane_req           req [NUM_DIR];
    t_lane_res           res [NUM_DIR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_width <= PAD_WIDTH_RST;
            r_straight  <= STRAIGHT_RST;
            r_diagonal  <= DIAGONAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PAD_WIDTH: r_pad_width <= i_cfg_data;
                CFG_STRAIGHT:  r_straight  <= i_cfg_data;
                CFG_DIAGONAL:  r_diagonal  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        nw = SUM_BITS'(i_in_data.weight_nw);
        n  = SUM_BITS'(i_in_data.weight_n);
        ne = SUM_BITS'(i_in_data.weight_ne);
        w  = SUM_BITS'(i_in_data.weight_w);
        o  = SUM_BITS'(i_in_data.weight_c);
        e  = SUM_BITS'(i_in_data.weight_e);
        sw = SUM_BITS'(i_in_data.weight_sw);
        s  = SUM_BITS'(i_in_data.weight_s);
        se = SUM_BITS'(i_in_data.weight_se);

        up = i_in_data.center_id - ID_BITS'(r_pad_width);
        dn = i_in_data.center_id + ID_BITS'(r_pad_width);

        open[DIR_N]  = (n != '0);
        open[DIR_NE] = (n != '0) && (ne != '0) && (e != '0);
        open[DIR_E]  = (e != '0);
        open[DIR_SE] = (e != '0) && (s != '0) && (se != '0);
        open[DIR_S]  = (s != '0);
        open[DIR_SW] = (w != '0) && (sw != '0) && (s != '0);
        open[DIR_W]  = (w != '0);
        open[DIR_NW] = (nw != '0) && (n != '0) && (w != '0);

        req[DIR_N]  = '{wsum: n + o, factor: r_straight, diag: 1'b0, id: up};
        req[DIR_NE] = '{wsum: n + ne + o + e, factor: r_diagonal, diag: 1'b1,
                        id: up + ID_BITS'(1)};
        req[DIR_E]  = '{wsum: e + o, factor: r_straight, diag: 1'b0,
                        id: i_in_data.center_id + ID_BITS'(1)};
        req[DIR_SE] = '{wsum: o + e + s + se, factor: r_diagonal, diag: 1'b1,
                        id: dn + ID_BITS'(1)};
        req[DIR_S]  = '{wsum: s + o, factor: r_straight, diag: 1'b0, id: dn};
        req[DIR_SW] = '{wsum: w + o + sw + s, factor: r_diagonal, diag: 1'b1,
                        id: dn - ID_BITS'(1)};
        req[DIR_W]  = '{wsum: w + o, factor: r_straight, diag: 1'b0,
                        id: i_in_data.center_id - ID_BITS'(1)};
        req[DIR_NW] = '{wsum: nw + n + w + o, factor: r_diagonal, diag: 1'b1,
                        id: up - ID_BITS'(1)};
    end

    for (genvar g = 0; g < NUM_DIR; g++) begin : g_lane
        wgne_lane u_lane (
            .i_clk  (i_clk),
            .i_load (load),
            .i_req  (req[g]),
            .o_res  (res[g])
        );
    end

    wgne_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_load      (load),
        .i_open      (open),
        .i_center    (i_in_data.center_id),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/core/wgne_checker.sv
// ----------------------------------------------------------------------------
// wgne_checker
// Port-level checks for the grid neighbour expansion core.
// ----------------------------------------------------------------------------
module wgne_checker
    import wgne_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input t_in_item                i_in_data,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input t_out_item               o_out_data,
    input logic                    i_cfg_we,
    input logic [CFG_IDX_BITS-1:0] i_cfg_addr,
    input logic [CFG_BITS-1:0]     i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.last)
        else $error("empty result not marked last");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.step_cost == '0 && o_out_data.direction == DIR_N)
        else $error("empty result carries cost or direction");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind weighted_grid_neighbour_expand_core wgne_checker u_wgne_checker (.*);
